@@ sv/qtu_pkg.sv @@
// ----------------------------------------------------------------------------
// qtu_pkg
// Shared types and constants of the grid Q-table update engine.
// ----------------------------------------------------------------------------
package qtu_pkg;

   localparam int GRID_ROWS   = 32;
   localparam int GRID_COLS   = 32;
   localparam int NUM_ACTIONS = 4;
   localparam int COUNT_BITS  = 16;

   localparam int ROW_W  = 5;
   localparam int COL_W  = 5;
   localparam int ACT_W  = 2;
   localparam int ADDR_W = ROW_W + COL_W + ACT_W;
   localparam int DEPTH  = GRID_ROWS * GRID_COLS * NUM_ACTIONS;
   localparam int Q_W    = 32;
   localparam int ENTRY_W = Q_W + COUNT_BITS;

   localparam int DVD_W = 36;
   localparam int DVS_W = 32;
   localparam int NUM_W = 52;

   localparam logic [16:0] DISC_ONE = 17'd65536;

   localparam logic [2:0] REG_MIN_X    = 3'd0;
   localparam logic [2:0] REG_MIN_Y    = 3'd1;
   localparam logic [2:0] REG_STEP_X   = 3'd2;
   localparam logic [2:0] REG_STEP_Y   = 3'd3;
   localparam logic [2:0] REG_ROWS     = 3'd4;
   localparam logic [2:0] REG_COLS     = 3'd5;
   localparam logic [2:0] REG_ACTIONS  = 3'd6;
   localparam logic [2:0] REG_DISCOUNT = 3'd7;

   localparam logic OP_QUERY  = 1'b0;
   localparam logic OP_UPDATE = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_AX_START,
      ST_AX_WAIT,
      ST_SC_RD,
      ST_SC_CMP,
      ST_OLD_RD,
      ST_OLD_DATA,
      ST_MUL,
      ST_NUM,
      ST_LR_START,
      ST_LR_WAIT,
      ST_WRITE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

@@ sv/grid_q_table_update.sv @@
// ----------------------------------------------------------------------------
// grid_q_table_update
// Tabular Q-learning engine over a 2-D grid of states, with greedy query.
// ----------------------------------------------------------------------------
// Use: items enter on req_ (tuser = opcode: 0 query, 1 update); one result
// item leaves on rsp_ per input item. Registers are to be written over the
// csr_ APB port while the engine is idle; the block does not enforce it.
// After reset the table (Q value and visit count per cell and action) is
// cleared, one entry a cycle; req_tready stays low meanwhile, register
// writes are taken as ever.
// Each cell index takes one pass of the shared divider, none when the
// coordinate lies below the origin. The action scan reads and compares
// each action in use in turn. A query takes two cell indices and the scan;
// an update takes four, the scan of the next cell, and one more divider
// pass for the learning-rate step.
// One item is worked on at a time. A finished result waits in the output
// register while rsp_tready is low; the next item may be accepted then, but
// its result is held back until the earlier one has been taken.
// ----------------------------------------------------------------------------
module grid_q_table_update
   import qtu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // tdata: state_x[31:0] state_y[63:32] next_x[95:64] next_y[127:96]
   //        taken_action[129:128] reward[161:130]
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [167:0] req_tdata,
   // tuser: opcode
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: best_action[1:0] max_q[33:2] new_q[65:34] row_index[70:66]
   //        col_index[75:71]
   output logic [79:0]  rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   // registers
   logic signed [31:0] min_x_ff, min_y_ff;
   logic [30:0]        step_x_ff, step_y_ff;
   logic [5:0]         rows_ff, cols_ff;
   logic [2:0]         acts_ff;
   logic [16:0]        disc_ff;
   logic               csr_wr;
   logic [2:0]         csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff  <= '0;
         min_y_ff  <= '0;
         step_x_ff <= 31'd65536;
         step_y_ff <= 31'd65536;
         rows_ff   <= 6'd32;
         cols_ff   <= 6'd32;
         acts_ff   <= 3'd4;
         disc_ff   <= 17'd58982;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_MIN_X:    min_x_ff  <= csr_pwdata;
            REG_MIN_Y:    min_y_ff  <= csr_pwdata;
            REG_STEP_X:   step_x_ff <= csr_pwdata[30:0];
            REG_STEP_Y:   step_y_ff <= csr_pwdata[30:0];
            REG_ROWS:     rows_ff   <= csr_pwdata[5:0];
            REG_COLS:     cols_ff   <= csr_pwdata[5:0];
            REG_ACTIONS:  acts_ff   <= csr_pwdata[2:0];
            REG_DISCOUNT: disc_ff   <= csr_pwdata[16:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_MIN_X:    csr_prdata = min_x_ff;
         REG_MIN_Y:    csr_prdata = min_y_ff;
         REG_STEP_X:   csr_prdata = {1'b0, step_x_ff};
         REG_STEP_Y:   csr_prdata = {1'b0, step_y_ff};
         REG_ROWS:     csr_prdata = {26'd0, rows_ff};
         REG_COLS:     csr_prdata = {26'd0, cols_ff};
         REG_ACTIONS:  csr_prdata = {29'd0, acts_ff};
         REG_DISCOUNT: csr_prdata = {15'd0, disc_ff};
         default:      csr_prdata = '0;
      endcase
   end

   // clamped settings
   logic [5:0]  nr, nc;
   logic [2:0]  na;
   logic [16:0] disc;

   assign nr   = (rows_ff == 6'd0) ? 6'd1 : (rows_ff > 6'(GRID_ROWS)) ? 6'(GRID_ROWS) : rows_ff;
   assign nc   = (cols_ff == 6'd0) ? 6'd1 : (cols_ff > 6'(GRID_COLS)) ? 6'(GRID_COLS) : cols_ff;
   assign na   = (acts_ff == 3'd0) ? 3'd1 : (acts_ff > 3'(NUM_ACTIONS)) ? 3'(NUM_ACTIONS) : acts_ff;
   assign disc = (disc_ff > DISC_ONE) ? DISC_ONE : disc_ff;

   // state
   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   clr_ff, clr_in;
   logic                op_ff, op_in;
   logic signed [31:0]  sx_ff, sx_in, sy_ff, sy_in, nx_ff, nx_in, ny_ff, ny_in;
   logic signed [31:0]  rew_ff, rew_in;
   logic [ACT_W-1:0]    ta_ff, ta_in;
   logic [1:0]          ax_ff, ax_in;
   logic [ROW_W-1:0]    r0_ff, r0_in, r1_ff, r1_in;
   logic [COL_W-1:0]    c0_ff, c0_in, c1_ff, c1_in;
   logic [ACT_W-1:0]    sa_ff, sa_in, act_ff, act_in;
   logic signed [31:0]  best_ff, best_in, q_ff, q_in, newq_ff, newq_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic signed [49:0]  prod_ff, prod_in;
   logic signed [NUM_W-1:0] num_ff, num_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [79:0]         rsp_data_ff, rsp_data_in;

   // memory and divider
   logic                we;
   logic [ADDR_W-1:0]   waddr, raddr;
   logic [ENTRY_W-1:0]  wdata, rdata;
   logic                div_start;
   logic [DVD_W-1:0]    div_dvd, quot;
   logic [DVS_W-1:0]    div_dvs;
   div_status_type      div_st;

   qtu_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   qtu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .quotient (quot),
      .status   (div_st)
   );

   // axis selection
   logic signed [31:0] ax_v, ax_o;
   logic [30:0]        ax_s;
   logic [5:0]         ax_n;
   logic signed [32:0] diff;
   logic [4:0]         ax_idx;
   logic signed [31:0] rq;
   logic [ACT_W-1:0]   ta_cl;
   logic signed [NUM_W-1:0] num_c;
   logic [NUM_W-1:0]   mag;
   logic signed [37:0] stepv, sumq;
   logic [COUNT_BITS-1:0] cnt_new;

   always_comb begin
      case (ax_ff)
         2'd0:    begin ax_v = sx_ff; ax_o = min_x_ff; ax_s = step_x_ff; ax_n = nr; end
         2'd1:    begin ax_v = sy_ff; ax_o = min_y_ff; ax_s = step_y_ff; ax_n = nc; end
         2'd2:    begin ax_v = nx_ff; ax_o = min_x_ff; ax_s = step_x_ff; ax_n = nr; end
         default: begin ax_v = ny_ff; ax_o = min_y_ff; ax_s = step_y_ff; ax_n = nc; end
      endcase
   end

   assign diff   = 33'(ax_v) - 33'(ax_o);
   assign ax_idx = (quot >= DVD_W'(ax_n)) ? 5'(ax_n - 6'd1) : quot[4:0];
   assign rq     = $signed(rdata[Q_W-1:0]);
   assign ta_cl  = ({1'b0, ta_ff} >= na) ? ACT_W'(na - 3'd1) : ta_ff;
   assign cnt_new = (rdata[ENTRY_W-1:Q_W] == {COUNT_BITS{1'b1}}) ?
                    rdata[ENTRY_W-1:Q_W] : rdata[ENTRY_W-1:Q_W] + 1'b1;
   assign num_c  = $signed({{4{rew_ff[31]}}, rew_ff, 16'd0}) + NUM_W'(prod_ff)
                 - $signed({{4{q_ff[31]}}, q_ff, 16'd0});
   assign mag    = num_ff[NUM_W-1] ? NUM_W'(-num_ff) : NUM_W'(num_ff);
   assign stepv  = num_ff[NUM_W-1] ? -$signed({2'b0, quot}) : $signed({2'b0, quot});
   assign sumq   = 38'(q_ff) + stepv;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      nx_in        = nx_ff;
      ny_in        = ny_ff;
      rew_in       = rew_ff;
      ta_in        = ta_ff;
      ax_in        = ax_ff;
      r0_in        = r0_ff;
      c0_in        = c0_ff;
      r1_in        = r1_ff;
      c1_in        = c1_ff;
      sa_in        = sa_ff;
      act_in       = act_ff;
      best_in      = best_ff;
      q_in         = q_ff;
      cnt_in       = cnt_ff;
      prod_in      = prod_ff;
      num_in       = num_ff;
      newq_in      = newq_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      we           = 1'b0;
      waddr        = {r0_ff, c0_ff, ta_cl};
      wdata        = {cnt_ff, newq_ff};
      raddr        = op_ff ? {r1_ff, c1_ff, sa_ff} : {r0_ff, c0_ff, sa_ff};
      div_start    = 1'b0;
      div_dvd      = {4'd0, diff[31:0]};
      div_dvs      = (ax_s == 31'd0) ? 32'd1 : {1'b0, ax_s};
      case (state_ff)
         ST_CLEAR: begin
            we     = 1'b1;
            waddr  = clr_ff;
            wdata  = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == {ADDR_W{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser;
               sx_in    = req_tdata[31:0];
               sy_in    = req_tdata[63:32];
               nx_in    = req_tdata[95:64];
               ny_in    = req_tdata[127:96];
               ta_in    = req_tdata[129:128];
               rew_in   = req_tdata[161:130];
               ax_in    = 2'd0;
               state_in = ST_AX_START;
            end
         end
         ST_AX_START: begin
            if (diff < 0) begin
               case (ax_ff)
                  2'd0:    r0_in = '0;
                  2'd1:    c0_in = '0;
                  2'd2:    r1_in = '0;
                  default: c1_in = '0;
               endcase
               ax_in = ax_ff + 1'b1;
               if (ax_ff == 2'd3 || (ax_ff == 2'd1 && op_ff == OP_QUERY)) begin
                  sa_in    = '0;
                  state_in = ST_SC_RD;
               end
            end else begin
               div_start = 1'b1;
               state_in  = ST_AX_WAIT;
            end
         end
         ST_AX_WAIT: begin
            if (div_st.done) begin
               case (ax_ff)
                  2'd0:    r0_in = ax_idx;
                  2'd1:    c0_in = ax_idx;
                  2'd2:    r1_in = ax_idx;
                  default: c1_in = ax_idx;
               endcase
               ax_in = ax_ff + 1'b1;
               if (ax_ff == 2'd3 || (ax_ff == 2'd1 && op_ff == OP_QUERY)) begin
                  sa_in    = '0;
                  state_in = ST_SC_RD;
               end else begin
                  state_in = ST_AX_START;
               end
            end
         end
         ST_SC_RD: begin
            state_in = ST_SC_CMP;
         end
         ST_SC_CMP: begin
            if (sa_ff == '0 || rq > best_ff) begin
               best_in = rq;
               act_in  = sa_ff;
            end
            sa_in = sa_ff + 1'b1;
            if ({1'b0, sa_ff} == na - 3'd1) begin
               state_in = (op_ff == OP_UPDATE) ? ST_OLD_RD : ST_DONE;
               newq_in  = '0;
            end else begin
               state_in = ST_SC_RD;
            end
         end
         ST_OLD_RD: begin
            raddr    = {r0_ff, c0_ff, ta_cl};
            state_in = ST_OLD_DATA;
         end
         ST_OLD_DATA: begin
            q_in     = rq;
            cnt_in   = cnt_new;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = $signed({1'b0, disc}) * best_ff;
            state_in = ST_NUM;
         end
         ST_NUM: begin
            num_in   = num_c;
            state_in = ST_LR_START;
         end
         ST_LR_START: begin
            div_start = 1'b1;
            div_dvd   = mag[NUM_W-1:16];
            div_dvs   = DVS_W'({1'b0, cnt_ff} + 17'd1);
            state_in  = ST_LR_WAIT;
         end
         ST_LR_WAIT: begin
            if (div_st.done) begin
               if (sumq > 38'sd2147483647) begin
                  newq_in = 32'sh7FFFFFFF;
               end else if (sumq < -38'sd2147483648) begin
                  newq_in = 32'sh80000000;
               end else begin
                  newq_in = sumq[31:0];
               end
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            we       = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'd0, c0_ff, r0_ff, newq_ff, best_ff, act_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      nx_ff       <= nx_in;
      ny_ff       <= ny_in;
      rew_ff      <= rew_in;
      ta_ff       <= ta_in;
      ax_ff       <= ax_in;
      r0_ff       <= r0_in;
      c0_ff       <= c0_in;
      r1_ff       <= r1_in;
      c1_ff       <= c1_in;
      sa_ff       <= sa_in;
      act_ff      <= act_in;
      best_ff     <= best_in;
      q_ff        <= q_in;
      cnt_ff      <= cnt_in;
      prod_ff     <= prod_in;
      num_ff      <= num_in;
      newq_ff     <= newq_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_tready)
      else $error("item accepted during table clear");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_st.busy)
      else $error("divider restarted while busy");

   a_row_in_grid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ({1'b0, rsp_tdata[70:66]} < nr))
      else $error("row index outside grid in use");

   a_query_new_q_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && op_ff == OP_QUERY) |-> (newq_ff == 32'sd0))
      else $error("query result carries non-zero new Q");
`endif

endmodule

@@ sv/qtu_ram.sv @@
// ----------------------------------------------------------------------------
// qtu_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module qtu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/qtu_div.sv @@
// ----------------------------------------------------------------------------
// qtu_div
// Shared unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qtu_div
   import qtu_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DVD_W-1:0]     dividend,
   input  logic [DVS_W-1:0]     divisor,
   output logic [DVD_W-1:0]     quotient,
   output div_status_type       status
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVS_W:0]   rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[DVS_W-1:0], quo_ff[DVD_W-1]};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

@@ sim/qtu_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtu_checker
// Watches the request and response streams of the Q-table engine, keeps its
// own copy of the table and registers, predicts each result and compares.
// ----------------------------------------------------------------------------
module qtu_checker
   import qtu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [167:0] req_tdata,
   input  logic         req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [79:0]  rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   input  logic         csr_pready,
   output int           fail_count,
   output int           pending
);

   typedef struct packed {
      logic [1:0]  best_action;
      logic [31:0] max_q;
      logic [31:0] new_q;
      logic [4:0]  row_index;
      logic [4:0]  col_index;
   } result_type;

   logic signed [31:0] q_tab [DEPTH];
   int unsigned        visits [DEPTH];
   logic signed [31:0] org_x, org_y;
   logic [30:0]        cell_w_x, cell_w_y;
   logic [5:0]         n_rows, n_cols;
   logic [2:0]         n_acts;
   logic [16:0]        gamma;
   result_type         expected_q [$];

   assign pending = expected_q.size();

   function automatic longint cell_of(longint v, longint origin, longint w, longint n);
      longint s;
      longint q;
      s = (w == 0) ? 1 : w;
      q = (v - origin) / s;
      if (q < 0) q = 0;
      if (q >= n) q = n - 1;
      return q;
   endfunction

   function automatic longint clampn(longint v, longint hi);
      return (v < 1) ? 1 : (v > hi) ? hi : v;
   endfunction

   function automatic int entry(longint r, longint c, longint a);
      return int'((r * GRID_COLS + c) * NUM_ACTIONS + a);
   endfunction

   task automatic scan_cell(input longint r, input longint c, input longint na,
                            output longint act, output longint best);
      longint v;
      act = 0;
      best = q_tab[entry(r, c, 0)];
      for (longint a = 1; a < na; a++) begin
         v = q_tab[entry(r, c, a)];
         if (v > best) begin
            best = v;
            act = a;
         end
      end
   endtask

   task automatic predict_item(input logic op, input logic [167:0] d);
      longint nr, nc, na, r0, c0, r1, c1, ta, act, best, newq, q, num, den, disc;
      int k;
      int unsigned cnt;
      result_type res;
      nr = clampn(longint'(n_rows), GRID_ROWS);
      nc = clampn(longint'(n_cols), GRID_COLS);
      na = clampn(longint'(n_acts), NUM_ACTIONS);
      r0 = cell_of(longint'($signed(d[31:0])), longint'(org_x), longint'(cell_w_x), nr);
      c0 = cell_of(longint'($signed(d[63:32])), longint'(org_y), longint'(cell_w_y), nc);
      newq = 0;
      if (op == OP_QUERY) begin
         scan_cell(r0, c0, na, act, best);
      end else begin
         r1 = cell_of(longint'($signed(d[95:64])), longint'(org_x), longint'(cell_w_x), nr);
         c1 = cell_of(longint'($signed(d[127:96])), longint'(org_y), longint'(cell_w_y), nc);
         ta = longint'(d[129:128]);
         if (ta > na - 1) ta = na - 1;
         disc = (gamma > DISC_ONE) ? 65536 : longint'(gamma);
         k = entry(r0, c0, ta);
         scan_cell(r1, c1, na, act, best);
         cnt = visits[k];
         if (cnt < (1 << COUNT_BITS) - 1) cnt++;
         visits[k] = cnt;
         q = q_tab[k];
         num = longint'($signed(d[161:130])) * 65536 + disc * best - q * 65536;
         den = 65536 * (longint'(cnt) + 1);
         newq = q + num / den;
         if (newq > 64'sd2147483647) newq = 64'sd2147483647;
         if (newq < -64'sd2147483648) newq = -64'sd2147483648;
         q_tab[k] = newq[31:0];
      end
      res.best_action = act[1:0];
      res.max_q = best[31:0];
      res.new_q = newq[31:0];
      res.row_index = r0[4:0];
      res.col_index = c0[4:0];
      expected_q = {expected_q, res};
   endtask

   always @(posedge clock) begin
      result_type got, exp_r;
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            q_tab[i] = 0;
            visits[i] = 0;
         end
         org_x = 32'sd0; org_y = 32'sd0; cell_w_x = 31'd65536; cell_w_y = 31'd65536;
         n_rows = 6'd32; n_cols = 6'd32; n_acts = 3'd4; gamma = 17'd58982;
         expected_q.delete();
         fail_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               REG_MIN_X:    org_x = csr_pwdata;
               REG_MIN_Y:    org_y = csr_pwdata;
               REG_STEP_X:   cell_w_x = csr_pwdata[30:0];
               REG_STEP_Y:   cell_w_y = csr_pwdata[30:0];
               REG_ROWS:     n_rows = csr_pwdata[5:0];
               REG_COLS:     n_cols = csr_pwdata[5:0];
               REG_ACTIONS:  n_acts = csr_pwdata[2:0];
               REG_DISCOUNT: gamma = csr_pwdata[16:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) predict_item(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[1:0], rsp_tdata[33:2], rsp_tdata[65:34],
                    rsp_tdata[70:66], rsp_tdata[75:71]};
            if (expected_q.size() == 0) begin
               $error("unexpected result item %h", rsp_tdata);
               fail_count++;
            end else begin
               exp_r = expected_q.pop_front();
               if (got.best_action !== exp_r.best_action) begin
                  $error("best_action exp %0d got %0d", exp_r.best_action, got.best_action);
                  fail_count++;
               end
               if (got.max_q !== exp_r.max_q) begin
                  $error("max_q exp %h got %h", exp_r.max_q, got.max_q);
                  fail_count++;
               end
               if (got.new_q !== exp_r.new_q) begin
                  $error("new_q exp %h got %h", exp_r.new_q, got.new_q);
                  fail_count++;
               end
               if (got.row_index !== exp_r.row_index) begin
                  $error("row_index exp %0d got %0d", exp_r.row_index, got.row_index);
                  fail_count++;
               end
               if (got.col_index !== exp_r.col_index) begin
                  $error("col_index exp %0d got %0d", exp_r.col_index, got.col_index);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives queries and updates into the Q-table engine under several register
// settings and random stalls; a checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
   import qtu_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [167:0] req_tdata = '0;
   logic         req_tuser = OP_QUERY;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [79:0]  rsp_tdata;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [4:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;
   int           fail_count;
   int           pending;
   int           send_idle = 0;
   int           take_idle = 0;
   longint       cycles = 0;

   localparam longint CYCLE_LIMIT = 3_000_000;

   always #4 clock = ~clock;

   grid_q_table_update dut (.*);

   qtu_checker checker_i (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= take_idle);

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send(input logic op, input logic [31:0] sx, input logic [31:0] sy,
                       input logic [31:0] nx, input logic [31:0] ny,
                       input logic [1:0] ta, input logic [31:0] rw);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {6'b0, rw, ta, ny, nx, sy, sx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   function automatic logic [31:0] coord();
      case ($urandom_range(9))
         0: return $urandom;
         1: return 32'h8000_0000;
         2: return 32'h7fff_ffff;
         default: return $urandom_range(40 * 65536) - 4 * 65536;
      endcase
   endfunction

   task automatic random_items(input int n);
      logic op;
      for (int i = 0; i < n; i++) begin
         op = ($urandom_range(3) != 0);
         send(op, coord(), coord(), coord(), coord(), 2'($urandom_range(3)),
              ($urandom_range(4) == 0) ? $urandom : $urandom_range(20 * 65536) - 10 * 65536);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, both operations, defaults
      send(OP_QUERY, 0, 0, 0, 0, 2'd0, 0);
      send(OP_UPDATE, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
           2'd3, 32'h7fff_ffff);
      send(OP_UPDATE, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 2'd3, 32'h8000_0000);
      for (int i = 0; i < 6; i++)
         send(OP_UPDATE, 65536 * 3, 65536 * 5, 65536 * 3, 65536 * 5, 2'd2, 32'h7fff_ffff);
      send(OP_QUERY, 65536 * 3, 65536 * 5, 0, 0, 2'd0, 0);
      send(OP_UPDATE, 65536, 65536, 32'hffff_ffff, 32'hffff_ffff, 2'd1, 32'h8000_0000);
      send(OP_QUERY, 32'h8000_0000, 32'h8000_0000, 0, 0, 2'd0, 0);
      drain();

      // zero and maximum steps, out-of-range sizes and discount, action saturation
      csr_write(REG_STEP_X, 0);
      csr_write(REG_STEP_Y, 32'hffff_ffff);
      csr_write(REG_ROWS, 0);
      csr_write(REG_COLS, 63);
      csr_write(REG_ACTIONS, 7);
      csr_write(REG_DISCOUNT, 32'h1_ffff);
      csr_write(REG_MIN_X, 32'h8000_0000);
      csr_write(REG_MIN_Y, 32'h7fff_ffff);
      send(OP_UPDATE, 32'h7fff_ffff, 32'h8000_0000, 5, 5, 2'd3, 32'h7fff_ffff);
      send(OP_QUERY, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 2'd0, 0);
      drain();
      csr_write(REG_ACTIONS, 2);
      csr_write(REG_DISCOUNT, 0);
      csr_write(REG_STEP_X, 0);
      csr_write(REG_MIN_X, 0);
      send(OP_UPDATE, 3, 0, 1, 0, 2'd3, 32'h0001_0000);
      send(OP_UPDATE, 3, 0, 1, 0, 2'd3, 32'h8000_0000);
      drain();

      csr_write(REG_MIN_X, -4 * 65536);
      csr_write(REG_MIN_Y, -4 * 65536);
      csr_write(REG_STEP_X, 65536 * 3 / 2);
      csr_write(REG_STEP_Y, 65536);
      csr_write(REG_ROWS, 8);
      csr_write(REG_COLS, 32);
      csr_write(REG_ACTIONS, 4);
      csr_write(REG_DISCOUNT, 32'(DISC_ONE));
      send_idle = 32;
      take_idle = 77;
      random_items(700);
      drain();

      csr_write(REG_ROWS, 32);
      csr_write(REG_COLS, 5);
      csr_write(REG_ACTIONS, 3);
      csr_write(REG_DISCOUNT, 58982);
      send_idle = 77;
      take_idle = 32;
      random_items(650);
      drain();

      csr_write(REG_ROWS, 1);
      csr_write(REG_COLS, 32);
      csr_write(REG_ACTIONS, 1);
      csr_write(REG_STEP_X, 65536);
      csr_write(REG_MIN_X, 0);
      csr_write(REG_MIN_Y, 0);
      send_idle = 0;
      take_idle = 0;
      random_items(650);
      drain();

      if (fail_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
sv/qtu_pkg.sv
sv/qtu_ram.sv
sv/qtu_div.sv
sv/grid_q_table_update.sv
sim/qtu_checker.sv
sim/testbench.sv
